### sv/vrp_pkg.sv
package vrp_pkg;

    localparam int CoordW   = 16;
    localparam int TrigW    = 16;
    localparam int FocalW   = 10;
    localparam int ScreenW  = 12;
    localparam int DepthW   = 17;
    localparam int NumW     = 27;   // focal (unsigned 10) times coord (signed 16)
    localparam int QuotW    = 27;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgAddrW-1:0] RegCosX  = 3'd0;
    localparam logic [CfgAddrW-1:0] RegSinX  = 3'd1;
    localparam logic [CfgAddrW-1:0] RegCosY  = 3'd2;
    localparam logic [CfgAddrW-1:0] RegSinY  = 3'd3;
    localparam logic [CfgAddrW-1:0] RegCosZ  = 3'd4;
    localparam logic [CfgAddrW-1:0] RegSinZ  = 3'd5;
    localparam logic [CfgAddrW-1:0] RegFocal = 3'd6;
    localparam logic [CfgAddrW-1:0] RegDepth = 3'd7;

    localparam logic signed [TrigW-1:0]  TrigOne     = 16'sd16384;
    localparam logic [FocalW-1:0]        FocalReset  = 10'd200;
    localparam logic signed [CoordW-1:0] DepthReset  = 16'sd8192;
    localparam logic signed [ScreenW-1:0] ScreenCtr  = 12'sd300;

    typedef struct packed {
        logic signed [TrigW-1:0] cos_x;
        logic signed [TrigW-1:0] sin_x;
        logic signed [TrigW-1:0] cos_y;
        logic signed [TrigW-1:0] sin_y;
        logic signed [TrigW-1:0] cos_z;
        logic signed [TrigW-1:0] sin_z;
        logic [FocalW-1:0]       focal;
        logic signed [CoordW-1:0] depth_off;
    } t_cfg;

    // Round a Q.26 sum (half up) to Q3.12 and saturate to 16 bits.
    function automatic logic signed [CoordW-1:0] to_q12(input logic signed [33:0] acc);
        logic signed [33:0] b;
        logic signed [19:0] q;
        begin
            b = acc + 34'sd8192;
            q = b[33:14];
            if (q > 20'sd32767)       to_q12 = 16'sh7fff;
            else if (q < -20'sd32768) to_q12 = 16'sh8000;
            else                      to_q12 = q[15:0];
        end
    endfunction

endpackage

### sv/vrp_rot.sv
// One rotation: two products each for a and b, registered, then summed and rounded.
// a = c*p + sa*s*q ; b = c*q + sb*s*p  (signs chosen by SignA)
module vrp_rot #(
    parameter bit SignA = 1'b0   // 0: a = c*p - s*q, b = s*p + c*q ; 1: a = c*p + s*q, b = c*q - s*p
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [vrp_pkg::TrigW-1:0]  i_c,
    input  logic signed [vrp_pkg::TrigW-1:0]  i_s,
    input  logic signed [vrp_pkg::CoordW-1:0] i_p,
    input  logic signed [vrp_pkg::CoordW-1:0] i_q,
    input  logic signed [vrp_pkg::CoordW-1:0] i_pass,
    output logic signed [vrp_pkg::CoordW-1:0] o_a,
    output logic signed [vrp_pkg::CoordW-1:0] o_b,
    output logic signed [vrp_pkg::CoordW-1:0] o_pass
);
    import vrp_pkg::*;

    logic signed [31:0] r_cp, r_sq, r_sp, r_cq;
    logic signed [CoordW-1:0] r_pass1;
    logic signed [CoordW-1:0] r_a, r_b, r_pass2;
    logic signed [33:0] n_sa, n_sb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cp    <= i_c * i_p;
            r_sq    <= i_s * i_q;
            r_sp    <= i_s * i_p;
            r_cq    <= i_c * i_q;
            r_pass1 <= i_pass;
            r_a     <= to_q12(n_sa);
            r_b     <= to_q12(n_sb);
            r_pass2 <= r_pass1;
        end
    end

    always_comb begin
        if (SignA) begin
            n_sa = 34'(r_cp) + 34'(r_sq);
            n_sb = 34'(r_cq) - 34'(r_sp);
        end else begin
            n_sa = 34'(r_cp) - 34'(r_sq);
            n_sb = 34'(r_sp) + 34'(r_cq);
        end
    end

    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_pass = r_pass2;
endmodule

### sv/vrp_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage,
// truncating toward zero, then +300 and saturate; the result is registered.
module vrp_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [vrp_pkg::NumW-1:0]   i_num,
    input  logic signed [vrp_pkg::DepthW-1:0] i_den,
    input  logic                              i_zero,
    output logic signed [vrp_pkg::ScreenW-1:0] o_screen
);
    import vrp_pkg::*;

    localparam int St = QuotW;

    logic [QuotW-1:0]  r_rem  [St+1];
    logic [QuotW-1:0]  r_quo  [St+1];
    logic [DepthW-1:0] r_den  [St+1];
    logic              r_neg  [St+1];
    logic              r_zero [St+1];
    logic signed [ScreenW-1:0] r_out;

    logic [QuotW-1:0]  n_nmag;
    logic [DepthW-1:0] n_dmag;
    logic signed [QuotW+1:0] n_res;

    always_comb begin
        n_nmag = i_num[NumW-1] ? QuotW'(-i_num) : QuotW'(i_num);
        n_dmag = i_den[DepthW-1] ? DepthW'(-i_den) : DepthW'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_nmag;
            r_quo[0]  <= '0;
            r_den[0]  <= n_dmag;
            r_neg[0]  <= i_num[NumW-1] ^ i_den[DepthW-1];
            r_zero[0] <= i_zero;
        end
    end

    for (genvar k = 0; k < St; k++) begin : g_st
        localparam int B = St - 1 - k;
        logic [QuotW+DepthW-1:0] n_sh;
        logic                    n_ge;
        assign n_sh = (QuotW+DepthW)'(r_den[k]) << B;
        assign n_ge = (QuotW+DepthW)'(r_rem[k]) >= n_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_ge ? QuotW'((QuotW+DepthW)'(r_rem[k]) - n_sh) : r_rem[k];
                r_quo[k+1]  <= r_quo[k] | (QuotW'(n_ge) << B);
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    always_comb begin
        n_res = r_neg[St] ? -$signed({2'b00, r_quo[St]}) : $signed({2'b00, r_quo[St]});
        n_res = n_res + (QuotW+2)'(300);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[St])                          r_out <= ScreenCtr;
            else if (n_res > (QuotW+2)'(2047))       r_out <= 12'sd2047;
            else if (n_res < -(QuotW+2)'(2047))      r_out <= -12'sd2047;
            else                                     r_out <= n_res[ScreenW-1:0];
        end
    end

    assign o_screen = r_out;
endmodule

### sv/vertex_rotate_project_top.sv
// Input to output: three rotations, each with a product and a sum stage, a depth stage,
// a focal-product stage, and a 27-stage divider with its input and output registers.
// Throughput: one vertex per cycle; the pipeline advances as a whole unless a finished
// output beat is stalled. Synchronous active-low reset clears the valid bits and
// restores register defaults; payload registers are not reset.
module vertex_rotate_project_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [vrp_pkg::CoordW-1:0]    i_vertex_x,
    input  logic signed [vrp_pkg::CoordW-1:0]    i_vertex_y,
    input  logic signed [vrp_pkg::CoordW-1:0]    i_vertex_z,
    input  logic                                 i_cfg_we,
    input  logic [vrp_pkg::CfgAddrW-1:0]         i_cfg_addr,
    input  logic [vrp_pkg::CfgDataW-1:0]         i_cfg_data,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [vrp_pkg::CoordW-1:0]    o_rotated_x,
    output logic signed [vrp_pkg::CoordW-1:0]    o_rotated_y,
    output logic signed [vrp_pkg::CoordW-1:0]    o_rotated_z,
    output logic signed [vrp_pkg::ScreenW-1:0]   o_screen_x,
    output logic signed [vrp_pkg::ScreenW-1:0]   o_screen_y,
    output logic                                 o_depth_zero
);
    import vrp_pkg::*;

    // Total pipeline depth in cycles; valid bits shift in lockstep with the data.
    localparam int Lat = 6 + 2 + (QuotW + 2);

    t_cfg r_cfg;
    logic [Lat-1:0] r_vld;
    logic           n_en;

    // The whole pipe moves together; it holds only when the last beat is stalled.
    assign n_en    = !(r_vld[Lat-1] && i_stall);
    assign o_stall = !n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_x     <= TrigOne;
            r_cfg.sin_x     <= '0;
            r_cfg.cos_y     <= TrigOne;
            r_cfg.sin_y     <= '0;
            r_cfg.cos_z     <= TrigOne;
            r_cfg.sin_z     <= '0;
            r_cfg.focal     <= FocalReset;
            r_cfg.depth_off <= DepthReset;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                RegCosX:  r_cfg.cos_x     <= i_cfg_data;
                RegSinX:  r_cfg.sin_x     <= i_cfg_data;
                RegCosY:  r_cfg.cos_y     <= i_cfg_data;
                RegSinY:  r_cfg.sin_y     <= i_cfg_data;
                RegCosZ:  r_cfg.cos_z     <= i_cfg_data;
                RegSinZ:  r_cfg.sin_z     <= i_cfg_data;
                RegFocal: r_cfg.focal     <= i_cfg_data[FocalW-1:0];
                RegDepth: r_cfg.depth_off <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[Lat-2:0], i_valid};
        end
    end

    // Rotation about X: y' = c*y - s*z, z' = s*y + c*z.
    logic signed [CoordW-1:0] w_y1, w_z1, w_x1;
    vrp_rot #(.SignA(1'b0)) u_rot_x (
        .i_clk(i_clk), .i_en(n_en), .i_c(r_cfg.cos_x), .i_s(r_cfg.sin_x),
        .i_p(i_vertex_y), .i_q(i_vertex_z), .i_pass(i_vertex_x),
        .o_a(w_y1), .o_b(w_z1), .o_pass(w_x1)
    );

    // Rotation about Y: x' = c*x + s*z, z' = c*z - s*x.
    logic signed [CoordW-1:0] w_x2, w_z2, w_y2;
    vrp_rot #(.SignA(1'b1)) u_rot_y (
        .i_clk(i_clk), .i_en(n_en), .i_c(r_cfg.cos_y), .i_s(r_cfg.sin_y),
        .i_p(w_x1), .i_q(w_z1), .i_pass(w_y1),
        .o_a(w_x2), .o_b(w_z2), .o_pass(w_y2)
    );

    // Rotation about Z: x' = c*x - s*y, y' = s*x + c*y.
    logic signed [CoordW-1:0] w_x3, w_y3, w_z3;
    vrp_rot #(.SignA(1'b0)) u_rot_z (
        .i_clk(i_clk), .i_en(n_en), .i_c(r_cfg.cos_z), .i_s(r_cfg.sin_z),
        .i_p(w_x2), .i_q(w_y2), .i_pass(w_z2),
        .o_a(w_x3), .o_b(w_y3), .o_pass(w_z3)
    );

    // Depth is registered first, then the focal products are registered in the next stage.
    logic signed [CoordW-1:0] r_px, r_py, r_pz, r_qx, r_qy, r_qz;
    logic signed [DepthW-1:0] r_depth, r_depth2;
    logic signed [NumW-1:0]   r_numx, r_numy;
    logic                     r_dz;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_px     <= w_x3;
            r_py     <= w_y3;
            r_pz     <= w_z3;
            r_depth  <= DepthW'(w_z3) + DepthW'(r_cfg.depth_off);
            r_qx     <= r_px;
            r_qy     <= r_py;
            r_qz     <= r_pz;
            r_numx   <= $signed({1'b0, r_cfg.focal}) * r_px;
            r_numy   <= $signed({1'b0, r_cfg.focal}) * r_py;
            r_depth2 <= r_depth;
            r_dz     <= (r_depth == '0);
        end
    end

    vrp_div u_div_x (
        .i_clk(i_clk), .i_en(n_en), .i_num(r_numx), .i_den(r_depth2),
        .i_zero(r_dz), .o_screen(o_screen_x)
    );
    vrp_div u_div_y (
        .i_clk(i_clk), .i_en(n_en), .i_num(r_numy), .i_den(r_depth2),
        .i_zero(r_dz), .o_screen(o_screen_y)
    );

    // Rotated coordinates and the flag ride a delay line matched to the dividers.
    localparam int Dly = QuotW + 2;
    logic signed [CoordW-1:0] r_dx [Dly];
    logic signed [CoordW-1:0] r_dy [Dly];
    logic signed [CoordW-1:0] r_dzc [Dly];
    logic                     r_dflag [Dly];

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_dx[0]    <= r_qx;
            r_dy[0]    <= r_qy;
            r_dzc[0]   <= r_qz;
            r_dflag[0] <= r_dz;
            for (int k = 1; k < Dly; k++) begin
                r_dx[k]    <= r_dx[k-1];
                r_dy[k]    <= r_dy[k-1];
                r_dzc[k]   <= r_dzc[k-1];
                r_dflag[k] <= r_dflag[k-1];
            end
        end
    end

    assign o_valid      = r_vld[Lat-1];
    assign o_rotated_x  = r_dx[Dly-1];
    assign o_rotated_y  = r_dy[Dly-1];
    assign o_rotated_z  = r_dzc[Dly-1];
    assign o_depth_zero = r_dflag[Dly-1];

    // A stalled output beat freezes the whole pipe, including the valid line.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rotated_x) && $stable(o_screen_x)))
        else $error("output beat changed while stalled");

    // Input is refused exactly when a finished beat waits.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting output beat");

    // A zero depth always shows the screen center on both axes.
    a_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_depth_zero) |-> (o_screen_x == ScreenCtr && o_screen_y == ScreenCtr))
        else $error("zero depth without centered screen output");
endmodule

### test/vertex_rotate_project_top_tb.sv
module vertex_rotate_project_top_tb;

    import vrp_pkg::*;

    // One output beat of the block, as the checker sees it.
    typedef struct {
        logic signed [CoordW-1:0]  rot_x;
        logic signed [CoordW-1:0]  rot_y;
        logic signed [CoordW-1:0]  rot_z;
        logic signed [ScreenW-1:0] scr_x;
        logic signed [ScreenW-1:0] scr_y;
        logic                      dz;
    } vertex_out_t;

    // The scoreboard keeps its own copy of the register file and, for each
    // accepted vertex, works out the rotated and projected beat it should produce.
    class projection_scoreboard;
        logic signed [TrigW-1:0]  trig [6];
        logic [FocalW-1:0]        focal;
        logic signed [CoordW-1:0] depth_off;
        vertex_out_t              pending_beats [$];
        int                       errors;

        function new();
            trig = '{TrigOne, 16'sd0, TrigOne, 16'sd0, TrigOne, 16'sd0};
            focal = FocalReset;
            depth_off = DepthReset;
            errors = 0;
        endfunction

        function void set_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
            case (idx)
                RegFocal: focal = val[FocalW-1:0];
                RegDepth: depth_off = val;
                default:  trig[idx] = val;
            endcase
        endfunction

        // Round half up from Q.26 to Q3.12, then saturate.
        function longint round_sat(longint acc);
            longint q;
            q = (acc + 8192) >>> 14;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return q;
        endfunction

        function longint screen_coord(longint coord, longint depth);
            longint s;
            s = (longint'(focal) * coord) / depth + 300;
            if (s > 2047) s = 2047;
            if (s < -2047) s = -2047;
            return s;
        endfunction

        function void note_vertex(logic signed [CoordW-1:0] vx,
                                  logic signed [CoordW-1:0] vy,
                                  logic signed [CoordW-1:0] vz);
            longint x, y, z, a, b, c, s, depth;
            vertex_out_t e;
            x = vx; y = vy; z = vz;
            c = trig[0]; s = trig[1];
            a = round_sat(c * y - s * z);
            b = round_sat(s * y + c * z);
            y = a; z = b;
            c = trig[2]; s = trig[3];
            a = round_sat(c * x + s * z);
            b = round_sat(c * z - s * x);
            x = a; z = b;
            c = trig[4]; s = trig[5];
            a = round_sat(c * x - s * y);
            b = round_sat(s * x + c * y);
            x = a; y = b;
            depth = z + longint'(depth_off);
            e.rot_x = CoordW'(x); e.rot_y = CoordW'(y); e.rot_z = CoordW'(z);
            if (depth == 0) begin
                e.scr_x = ScreenCtr; e.scr_y = ScreenCtr; e.dz = 1'b1;
            end else begin
                e.scr_x = ScreenW'(screen_coord(x, depth));
                e.scr_y = ScreenW'(screen_coord(y, depth));
                e.dz = 1'b0;
            end
            pending_beats.push_back(e);
        endfunction

        function void check_beat(vertex_out_t act);
            vertex_out_t e;
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected output beat %p", $time, act);
                errors++;
                return;
            end
            e = pending_beats.pop_front();
            if (act.rot_x !== e.rot_x || act.rot_y !== e.rot_y || act.rot_z !== e.rot_z ||
                act.scr_x !== e.scr_x || act.scr_y !== e.scr_y || act.dz !== e.dz) begin
                $display("%0t: mismatch expected %p actual %p", $time, e, act);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [CoordW-1:0]  i_vertex_x = '0;
    logic signed [CoordW-1:0]  i_vertex_y = '0;
    logic signed [CoordW-1:0]  i_vertex_z = '0;
    logic                      i_cfg_we = 1'b0;
    logic [CfgAddrW-1:0]       i_cfg_addr = '0;
    logic [CfgDataW-1:0]       i_cfg_data = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [CoordW-1:0]  o_rotated_x, o_rotated_y, o_rotated_z;
    logic signed [ScreenW-1:0] o_screen_x, o_screen_y;
    logic                      o_depth_zero;

    vertex_rotate_project_top dut (.*);

    projection_scoreboard sb = new();

    // Idle percentages for each side, changed from phase to phase.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // When nonzero, the receiver holds off for this many more cycles.
    int rx_hold_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The receiver decides its stall at each falling edge, so the value is settled
    // well before the rising edge at which the block samples it.
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            i_stall = 1'b1;
            rx_hold_cycles = rx_hold_cycles - 1;
        end else begin
            i_stall = ($urandom_range(99) < rx_idle_pct);
        end
    end

    // An output beat is taken at a rising edge with valid high and stall low.
    always @(posedge i_clk) begin
        vertex_out_t act;
        if (i_rst_n && o_valid && !i_stall) begin
            act.rot_x = o_rotated_x; act.rot_y = o_rotated_y; act.rot_z = o_rotated_z;
            act.scr_x = o_screen_x;  act.scr_y = o_screen_y;  act.dz = o_depth_zero;
            sb.check_beat(act);
        end
    end

    // Offers one vertex, possibly after random idle cycles, and returns at the
    // falling edge after the beat was accepted. Valid stays high when the next
    // call does not idle, so back-to-back beats are possible.
    task automatic send_vertex(input logic [CoordW-1:0] vx, input logic [CoordW-1:0] vy,
                               input logic [CoordW-1:0] vz);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_vertex_x = vx;
        i_vertex_y = vy;
        i_vertex_z = vz;
        do @(posedge i_clk); while (o_stall);
        sb.note_vertex(vx, vy, vz);
        @(negedge i_clk);
    endtask

    // Lets every expected beat come out, then waits past the pipeline depth so
    // nothing is still in flight before the registers change.
    task automatic drain;
        i_valid = 1'b0;
        while (sb.pending_beats.size() != 0) @(negedge i_clk);
        repeat (45) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(input logic [CfgDataW-1:0] cx, input logic [CfgDataW-1:0] sx,
                             input logic [CfgDataW-1:0] cy, input logic [CfgDataW-1:0] sy,
                             input logic [CfgDataW-1:0] cz, input logic [CfgDataW-1:0] sz,
                             input logic [CfgDataW-1:0] fl, input logic [CfgDataW-1:0] dp);
        write_reg(RegCosX, cx);
        write_reg(RegSinX, sx);
        write_reg(RegCosY, cy);
        write_reg(RegSinY, sy);
        write_reg(RegCosZ, cz);
        write_reg(RegSinZ, sz);
        write_reg(RegFocal, fl);
        write_reg(RegDepth, dp);
    endtask

    // Trig values: mostly in range, with the extremes and raw patterns mixed in.
    function automatic logic [CfgDataW-1:0] pick_trig();
        case ($urandom_range(5))
            0:       return 16'sd16384;
            1:       return -16'sd16384;
            2:       return CfgDataW'($urandom);
            default: return CfgDataW'($urandom_range(32768) - 16384);
        endcase
    endfunction

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed beats at reset settings: extremes and a depth that cancels out.
        send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
        send_vertex(16'sh0000, 16'sh0000, 16'sh0000);
        send_vertex(16'sh1000, -16'sh1000, -16'sd8192);
        send_vertex(16'sh7fff, 16'sh8000, -16'sd8191);
        drain();

        // Both trig terms at full scale saturate the rotations.
        write_all(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
                  16'sd16384, 16'sd16384, 16'd1023, 16'sh7fff);
        send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
        send_vertex(16'sh7fff, 16'sh8000, 16'sh7fff);
        drain();
        write_all(-16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384,
                  16'sd16384, -16'sd16384, 16'd1, 16'sh8000);
        send_vertex(16'sh7fff, 16'sh8000, 16'sh0001);
        send_vertex(16'sh8000, 16'sh7fff, 16'shffff);
        send_vertex(16'sh0001, 16'shffff, 16'sh4000);
        drain();

        // Zero focal length and a zero depth offset with the identity rotation.
        write_all(16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
                  16'sd16384, 16'sd0, 16'd0, 16'sd0);
        send_vertex(16'sh1234, 16'sh4321, 16'sh0000);
        send_vertex(16'sh7fff, 16'sh8000, 16'sh0100);
        drain();
        write_reg(RegFocal, 16'hffff);
        send_vertex(16'sh0400, -16'sh0400, 16'sh0001);
        send_vertex(16'sh7fff, 16'sh8000, -16'sh0001);
        send_vertex(16'sh2000, 16'sh2000, 16'sh0000);
        drain();

        // Random phases: sender idles lightly, then heavily, then nobody idles.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 75 : 0;
            rx_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 19 : 0;
            for (int setting = 0; setting < 5; setting++) begin
                write_all(pick_trig(), pick_trig(), pick_trig(), pick_trig(),
                          pick_trig(), pick_trig(),
                          (setting == 0) ? 16'd1023 : CfgDataW'($urandom_range(1023)),
                          (setting == 1) ? 16'h8000 :
                          (setting == 2) ? 16'h7fff : CfgDataW'($urandom));
                for (int n = 0; n < 130; n++) begin
                    // A long hold-off lets the pipeline fill and back up into the input.
                    if (setting == 2 && n == 20) rx_hold_cycles = 200;
                    send_vertex(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
                end
                drain();
            end
        end

        if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
